>>> rtl/mpfb_pkg.sv
package mpfb_pkg;

	localparam int COLUMNS = 128;
	localparam int PAGES   = 8;
	localparam int ROWS    = 8 * PAGES;
	localparam int DEPTH   = COLUMNS * PAGES;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int ADDR_W  = $clog2(DEPTH);

	localparam logic [7:0] LAST_COL = 8'(COLUMNS - 1);
	localparam logic [7:0] LAST_ROW = 8'(ROWS - 1);

	typedef enum logic [2:0] {
		FN_DRAW      = 3'd0,
		FN_READ_PIX  = 3'd1,
		FN_FILL      = 3'd2,
		FN_CLEAR     = 3'd3,
		FN_READ_BYTE = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX,
		ST_FRD,
		ST_FWR,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic       fin;
		logic       pix;
		logic [7:0] gram;
	} rsp_t;

	function automatic logic [ADDR_W-1:0] mem_addr(logic [PAGE_W-1:0] pg,
		logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(pg) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
	endfunction

endpackage

>>> rtl/mono_page_framebuffer.sv
// Pixel draw/read and byte read: RAM read on accept, result registered from
// ST_PIX (read then write on the display RAM); no new item until idle.
// Fill: a read and a write per byte touched (columns x pages spanned); an
// empty fill or unused func code is answered at the accepting edge. Clear all
// zeroes every RAM byte, then answers. A result held by rsp_ready delays the
// next item. Reset: the RAM is swept to zero, ready stays low meanwhile.
module mono_page_framebuffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] func,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] end_x,
	input  logic [7:0] end_y,
	input  logic       pixel_on,
	input  logic [2:0] page_sel,
	input  logic [6:0] column_sel,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic       pixel_value,
	output logic [7:0] gram_byte
);

	mpfb_pkg::rsp_t rsp;
	logic out_free;
	logic mem_we;
	logic [mpfb_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata, mem_rdata;
	logic rsp_valid_q;
	logic pix_q;
	logic [7:0] gram_q;

	assign out_free = !rsp_valid_q || rsp_ready;

	mpfb_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.func       (func),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.pixel_on   (pixel_on),
		.page_sel   (page_sel),
		.column_sel (column_sel),
		.out_free   (out_free),
		.rsp        (rsp),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	mpfb_ram #(
		.WIDTH (8),
		.DEPTH (mpfb_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp.fin && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.fin && out_free) begin
			pix_q  <= rsp.pix;
			gram_q <= rsp.gram;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign pixel_value = pix_q;
	assign gram_byte   = gram_q;

endmodule

>>> rtl/mpfb_ram.sv
module mpfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/mpfb_seq.sv
module mpfb_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [2:0]                 func,
	input  logic [7:0]                 pos_x,
	input  logic [7:0]                 pos_y,
	input  logic [7:0]                 end_x,
	input  logic [7:0]                 end_y,
	input  logic                       pixel_on,
	input  logic [2:0]                 page_sel,
	input  logic [6:0]                 column_sel,
	input  logic                       out_free,
	output mpfb_pkg::rsp_t             rsp,
	output logic                       mem_we,
	output logic [mpfb_pkg::ADDR_W-1:0] mem_waddr,
	output logic [7:0]                 mem_wdata,
	output logic [mpfb_pkg::ADDR_W-1:0] mem_raddr,
	input  logic [7:0]                 mem_rdata
);

	mpfb_pkg::state_t state_q, state_d;
	logic init_q;
	logic [mpfb_pkg::ADDR_W-1:0] clr_q;

	logic [2:0] func_q;
	logic [mpfb_pkg::ADDR_W-1:0] addr_q;
	logic [7:0] mask_q;
	logic ok_q;
	logic on_q;
	logic [7:0] fx_q, fx1_q;
	logic [mpfb_pkg::PAGE_W-1:0] fr_q, fr0_q, fr1_q;
	logic [2:0] fy0_q, fy1_q;
	logic res_pix_q;
	logic [7:0] res_gram_q;

	logic accept;
	logic [7:0] ex_c, ey_c;
	logic fill_empty, pix_ok, byte_ok, immediate;
	logic [mpfb_pkg::PAGE_W-1:0] pix_page, fill_page;
	logic [7:0] pix_mask, fill_mask;
	logic [2:0] lo, hi;
	logic [mpfb_pkg::ADDR_W-1:0] port_addr, fill_addr;
	logic clr_done, last_blk, last_col;
	logic fin, res_pix;
	logic [7:0] res_gram;

	function automatic logic [7:0] merge(logic [7:0] d, logic [7:0] m, logic on);
		return on ? (d | m) : (d & ~m);
	endfunction

	assign req_ready = (state_q == mpfb_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;

	assign ex_c = (end_x > mpfb_pkg::LAST_COL) ? mpfb_pkg::LAST_COL : end_x;
	assign ey_c = (end_y > mpfb_pkg::LAST_ROW) ? mpfb_pkg::LAST_ROW : end_y;
	assign fill_empty = (pos_x > ex_c) || (pos_y > ey_c);
	assign pix_ok  = (int'(pos_x) < mpfb_pkg::COLUMNS) && (int'(pos_y) < mpfb_pkg::ROWS);
	assign byte_ok = (int'(page_sel) < mpfb_pkg::PAGES)
		&& (int'(column_sel) < mpfb_pkg::COLUMNS);

	assign pix_page = mpfb_pkg::PAGE_W'(mpfb_pkg::PAGES - 1) - mpfb_pkg::PAGE_W'(pos_y >> 3);
	assign pix_mask = 8'h80 >> pos_y[2:0];
	assign port_addr = (func == mpfb_pkg::FN_READ_BYTE)
		? mpfb_pkg::mem_addr(mpfb_pkg::PAGE_W'(page_sel), mpfb_pkg::COL_W'(column_sel))
		: mpfb_pkg::mem_addr(pix_page, mpfb_pkg::COL_W'(pos_x));

	// fill walk: one byte per column and page, bits limited at the end pages
	assign fill_page = mpfb_pkg::PAGE_W'(mpfb_pkg::PAGES - 1) - fr_q;
	assign fill_addr = mpfb_pkg::mem_addr(fill_page, mpfb_pkg::COL_W'(fx_q));
	assign lo = (fr_q == fr0_q) ? fy0_q : 3'd0;
	assign hi = (fr_q == fr1_q) ? fy1_q : 3'd7;
	assign fill_mask = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
	assign last_blk = (fr_q == fr1_q);
	assign last_col = (fx_q == fx1_q);

	assign clr_done = (clr_q == mpfb_pkg::ADDR_W'(mpfb_pkg::DEPTH - 1));
	assign mem_raddr = (state_q == mpfb_pkg::ST_IDLE) ? port_addr : fill_addr;

	always_comb begin
		immediate = 1'b1;
		unique case (func) inside
			mpfb_pkg::FN_DRAW, mpfb_pkg::FN_READ_PIX, mpfb_pkg::FN_READ_BYTE,
			mpfb_pkg::FN_CLEAR: immediate = 1'b0;
			mpfb_pkg::FN_FILL: immediate = fill_empty;
			default: immediate = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpfb_pkg::ST_CLEAR: begin
				if (clr_done) begin
					state_d = (init_q || out_free) ? mpfb_pkg::ST_IDLE : mpfb_pkg::ST_HOLD;
				end
			end
			mpfb_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (func) inside
						mpfb_pkg::FN_DRAW, mpfb_pkg::FN_READ_PIX,
						mpfb_pkg::FN_READ_BYTE: state_d = mpfb_pkg::ST_PIX;
						mpfb_pkg::FN_CLEAR: state_d = mpfb_pkg::ST_CLEAR;
						mpfb_pkg::FN_FILL: begin
							if (!fill_empty) begin
								state_d = mpfb_pkg::ST_FRD;
							end else if (!out_free) begin
								state_d = mpfb_pkg::ST_HOLD;
							end
						end
						default: begin
							if (!out_free) begin
								state_d = mpfb_pkg::ST_HOLD;
							end
						end
					endcase
				end
			end
			mpfb_pkg::ST_PIX: begin
				state_d = out_free ? mpfb_pkg::ST_IDLE : mpfb_pkg::ST_HOLD;
			end
			mpfb_pkg::ST_FRD: state_d = mpfb_pkg::ST_FWR;
			mpfb_pkg::ST_FWR: begin
				if (last_blk && last_col) begin
					state_d = out_free ? mpfb_pkg::ST_IDLE : mpfb_pkg::ST_HOLD;
				end else begin
					state_d = mpfb_pkg::ST_FRD;
				end
			end
			mpfb_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = mpfb_pkg::ST_IDLE;
				end
			end
			default: state_d = mpfb_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_addr;
		mem_wdata = merge(mem_rdata, fill_mask, on_q);
		fin       = 1'b0;
		res_pix   = 1'b0;
		res_gram  = 8'h00;
		unique case (state_q)
			mpfb_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'h00;
				fin       = clr_done && !init_q;
			end
			mpfb_pkg::ST_IDLE: fin = accept && immediate;
			mpfb_pkg::ST_PIX: begin
				mem_waddr = addr_q;
				mem_wdata = merge(mem_rdata, mask_q, on_q);
				mem_we    = (func_q == mpfb_pkg::FN_DRAW) && ok_q;
				fin       = 1'b1;
				res_pix   = (func_q == mpfb_pkg::FN_READ_PIX) && ok_q && |(mem_rdata & mask_q);
				res_gram  = ((func_q == mpfb_pkg::FN_READ_BYTE) && ok_q) ? mem_rdata : 8'h00;
			end
			mpfb_pkg::ST_FRD: fin = 1'b0;
			mpfb_pkg::ST_FWR: begin
				mem_we = 1'b1;
				fin    = last_blk && last_col;
			end
			mpfb_pkg::ST_HOLD: begin
				fin      = 1'b1;
				res_pix  = res_pix_q;
				res_gram = res_gram_q;
			end
			default: fin = 1'b0;
		endcase
	end

	assign rsp.fin  = fin;
	assign rsp.pix  = res_pix;
	assign rsp.gram = res_gram;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpfb_pkg::ST_CLEAR;
			init_q  <= 1'b1;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mpfb_pkg::ST_CLEAR) begin
				if (clr_done) begin
					clr_q  <= '0;
					init_q <= 1'b0;
				end else begin
					clr_q <= clr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			on_q   <= pixel_on;
			addr_q <= port_addr;
			mask_q <= pix_mask;
			ok_q   <= (func == mpfb_pkg::FN_READ_BYTE) ? byte_ok : pix_ok;
			fx_q   <= pos_x;
			fx1_q  <= ex_c;
			fr_q   <= mpfb_pkg::PAGE_W'(pos_y >> 3);
			fr0_q  <= mpfb_pkg::PAGE_W'(pos_y >> 3);
			fr1_q  <= mpfb_pkg::PAGE_W'(ey_c >> 3);
			fy0_q  <= pos_y[2:0];
			fy1_q  <= ey_c[2:0];
		end else if (state_q == mpfb_pkg::ST_FWR) begin
			if (last_blk) begin
				fr_q <= fr0_q;
				fx_q <= fx_q + 8'd1;
			end else begin
				fr_q <= fr_q + 1'b1;
			end
		end
		if (fin && !out_free) begin
			res_pix_q  <= res_pix;
			res_gram_q <= res_gram;
		end
	end

	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !req_ready)
		else $error("item taken during power-up clear");

	a_pix_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpfb_pkg::ST_PIX) |-> $past(accept))
		else $error("pixel access without item");

	a_rmw_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpfb_pkg::ST_FWR) |-> (mem_waddr == $past(mem_raddr)))
		else $error("fill write address differs from read");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpfb_pkg::ST_FRD) |-> (fx_q <= fx1_q) && (fr_q >= fr0_q)
			&& (fr_q <= fr1_q))
		else $error("fill walk out of rectangle");

endmodule

>>> sim/mono_page_framebuffer_tb.sv
`timescale 1ns / 1ps

module mono_page_framebuffer_tb;

	localparam logic [2:0] FN_SPARE_MIN = 3'd5;
	localparam logic [2:0] FN_SPARE_MAX = 3'd7;
	localparam int N_RANDOM    = 1530;
	localparam int DRAIN_EVERY = 150;
	localparam int IDLE_LIMIT  = 20000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [2:0] func;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] end_x;
		logic [7:0] end_y;
		logic       pixel_on;
		logic [2:0] page_sel;
		logic [6:0] column_sel;
		bit         drain;
	} fb_cmd_t;

	typedef struct {
		logic       pix;
		logic [7:0] gram;
	} fb_readout_t;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	logic [2:0] func;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] end_x;
	logic [7:0] end_y;
	logic       pixel_on;
	logic [2:0] page_sel;
	logic [6:0] column_sel;
	logic       rsp_valid;
	logic       rsp_ready;
	logic       pixel_value;
	logic [7:0] gram_byte;

	logic [7:0]  frame [mpfb_pkg::DEPTH];
	fb_cmd_t     cmd_q[$];
	fb_readout_t readout_q[$];
	fb_cmd_t     cur_cmd;
	fb_readout_t want;
	int          errors;
	int          idle_cycles;
	bit          req_fire;
	int          req_gap;
	int          req_quiet;
	int          rsp_stall;
	int          rsp_quiet;

	mono_page_framebuffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.end_x(end_x),
		.end_y(end_y),
		.pixel_on(pixel_on),
		.page_sel(page_sel),
		.column_sel(column_sel),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.pixel_value(pixel_value),
		.gram_byte(gram_byte)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// row y sits in page PAGES-1-y/8, bit 7-y%8
	function automatic void set_pixel(int x, int y, bit on);
		int         a;
		logic [7:0] m;
		if (x >= mpfb_pkg::COLUMNS || y >= mpfb_pkg::ROWS)
			return;
		a = (mpfb_pkg::PAGES - 1 - y / 8) * mpfb_pkg::COLUMNS + x;
		m = 8'h80 >> (y % 8);
		frame[a] = on ? (frame[a] | m) : (frame[a] & ~m);
	endfunction

	function automatic fb_readout_t apply_to_frame(fb_cmd_t c);
		fb_readout_t r;
		int          x;
		int          y;
		int          x1;
		int          y1;
		r.pix = 1'b0;
		r.gram = 8'h00;
		x = int'(c.pos_x);
		y = int'(c.pos_y);
		case (c.func)
			mpfb_pkg::FN_DRAW: set_pixel(x, y, c.pixel_on);
			mpfb_pkg::FN_READ_PIX: begin
				if (x < mpfb_pkg::COLUMNS && y < mpfb_pkg::ROWS)
					r.pix = frame[(mpfb_pkg::PAGES - 1 - y / 8) * mpfb_pkg::COLUMNS + x]
						[7 - y % 8];
			end
			mpfb_pkg::FN_FILL: begin
				x1 = (c.end_x > mpfb_pkg::LAST_COL) ? int'(mpfb_pkg::LAST_COL)
					: int'(c.end_x);
				y1 = (c.end_y > mpfb_pkg::LAST_ROW) ? int'(mpfb_pkg::LAST_ROW)
					: int'(c.end_y);
				for (x = int'(c.pos_x); x <= x1; x++)
					for (y = int'(c.pos_y); y <= y1; y++)
						set_pixel(x, y, c.pixel_on);
			end
			mpfb_pkg::FN_CLEAR: begin
				foreach (frame[i])
					frame[i] = 8'h00;
			end
			mpfb_pkg::FN_READ_BYTE: begin
				if (c.page_sel < mpfb_pkg::PAGES && c.column_sel < mpfb_pkg::COLUMNS)
					r.gram = frame[int'(c.page_sel) * mpfb_pkg::COLUMNS
						+ int'(c.column_sel)];
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// half the time a small corner so reads find drawn pixels, some off-screen
	function automatic logic [7:0] pick_coord(int lim, int hot);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 8'($urandom_range(0, hot - 1));
		if (r < 85)
			return 8'($urandom_range(0, lim - 1));
		return 8'($urandom_range(lim, 255));
	endfunction

	function automatic logic [7:0] pick_end(logic [7:0] start);
		int r;
		int e;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'($urandom_range(0, start));
		if (r == 1)
			return 8'hFF;
		e = int'(start) + int'($urandom_range(0, 15));
		return (e > 255) ? 8'hFF : 8'(e);
	endfunction

	function automatic void queue_cmd(logic [2:0] f, logic [7:0] x, logic [7:0] y,
		logic [7:0] ex, logic [7:0] ey, logic on, logic [2:0] pg, logic [6:0] col);
		fb_cmd_t c;
		c.func = f;
		c.pos_x = x;
		c.pos_y = y;
		c.end_x = ex;
		c.end_y = ey;
		c.pixel_on = on;
		c.page_sel = pg;
		c.column_sel = col;
		c.drain = 1'b0;
		cmd_q.push_back(c);
	endfunction

	// request side
	always @(negedge clk) begin
		if (arst_n && !(req_valid && !req_fire)) begin
			if (req_gap > 0) begin
				req_valid <= 1'b0;
				req_gap--;
			end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && readout_q.size() > 0)) begin
				cur_cmd = cmd_q.pop_front();
				req_valid <= 1'b1;
				func <= cur_cmd.func;
				pos_x <= cur_cmd.pos_x;
				pos_y <= cur_cmd.pos_y;
				end_x <= cur_cmd.end_x;
				end_y <= cur_cmd.end_y;
				pixel_on <= cur_cmd.pixel_on;
				page_sel <= cur_cmd.page_sel;
				column_sel <= cur_cmd.column_sel;
				if (req_quiet > 0) begin
					req_quiet--;
				end else begin
					if ($urandom_range(0, 49) == 0)
						req_quiet = $urandom_range(30, 120);
					req_gap = pick_gap();
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (rsp_stall > 0) begin
			rsp_ready <= 1'b0;
			rsp_stall--;
		end else begin
			rsp_ready <= 1'b1;
			if (rsp_quiet > 0)
				rsp_quiet--;
			else if ($urandom_range(0, 3) == 0)
				rsp_stall = pick_gap();
			else if ($urandom_range(0, 59) == 0)
				rsp_quiet = $urandom_range(30, 120);
		end
	end

	// check results before predicting the item taken on the same edge
	always @(posedge clk) begin
		req_fire = req_valid && req_ready;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (readout_q.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("unexpected result: pixel_value %b gram_byte %h",
						pixel_value, gram_byte);
				errors++;
			end else begin
				want = readout_q.pop_front();
				if (pixel_value !== want.pix || gram_byte !== want.gram) begin
					if (errors < MAX_REPORTS)
						$display("result error: pixel_value %b (exp %b) gram_byte %h (exp %h)",
							pixel_value, want.pix, gram_byte, want.gram);
					errors++;
				end
			end
		end
		if (arst_n && req_fire)
			readout_q.push_back(apply_to_frame(cur_cmd));
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("mono_page_framebuffer: mismatch");
			$finish;
		end
	end

	initial begin
		fb_cmd_t c;
		int      i;
		int      k;
		arst_n = 1'b0;
		req_valid = 1'b0;
		rsp_ready = 1'b0;
		func = '0;
		pos_x = '0;
		pos_y = '0;
		end_x = '0;
		end_y = '0;
		pixel_on = 1'b0;
		page_sel = '0;
		column_sel = '0;
		errors = 0;
		idle_cycles = 0;
		req_fire = 1'b0;
		req_gap = 0;
		req_quiet = 0;
		rsp_stall = 0;
		rsp_quiet = 0;
		foreach (frame[j])
			frame[j] = 8'h00;

		// corners, off-screen pixels, clamped and empty rectangles
		queue_cmd(mpfb_pkg::FN_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_DRAW, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 3'd7, 7'd127);
		queue_cmd(mpfb_pkg::FN_DRAW, 8'd128, 8'd5, 8'd0, 8'd0, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_DRAW, 8'd5, 8'd64, 8'd0, 8'd0, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_DRAW, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 3'd7, 7'd127);
		queue_cmd(mpfb_pkg::FN_READ_PIX, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_PIX, 8'd127, 8'd63, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_PIX, 8'd128, 8'd5, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_PIX, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd127);
		queue_cmd(mpfb_pkg::FN_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_PIX, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_FILL, 8'd10, 8'd5, 8'd20, 8'd30, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_FILL, 8'd120, 8'd60, 8'd255, 8'd255, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_FILL, 8'd30, 8'd10, 8'd20, 8'd40, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_FILL, 8'd200, 8'd0, 8'd255, 8'd10, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd127);
		queue_cmd(mpfb_pkg::FN_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd4, 7'd15);
		queue_cmd(mpfb_pkg::FN_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 7'd127);
		for (k = FN_SPARE_MIN; k <= FN_SPARE_MAX; k++)
			queue_cmd(3'(k), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd7, 7'd127);
		queue_cmd(mpfb_pkg::FN_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 3'd0, 7'd0);
		queue_cmd(mpfb_pkg::FN_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd3, 7'd64);
		queue_cmd(mpfb_pkg::FN_FILL, 8'd0, 8'd0, 8'd127, 8'd63, 1'b0, 3'd0, 7'd0);

		for (i = 0; i < N_RANDOM; i++) begin
			c.func = 3'($urandom);
			c.pos_x = 8'($urandom);
			c.pos_y = 8'($urandom);
			c.end_x = 8'($urandom);
			c.end_y = 8'($urandom);
			c.pixel_on = 1'($urandom);
			c.page_sel = 3'($urandom);
			c.column_sel = 7'($urandom);
			c.drain = (i % DRAIN_EVERY == 0);
			k = $urandom_range(0, 99);
			if (k < 28) begin
				c.func = mpfb_pkg::FN_DRAW;
				c.pos_x = pick_coord(mpfb_pkg::COLUMNS, 32);
				c.pos_y = pick_coord(mpfb_pkg::ROWS, 24);
			end else if (k < 53) begin
				c.func = mpfb_pkg::FN_READ_PIX;
				c.pos_x = pick_coord(mpfb_pkg::COLUMNS, 32);
				c.pos_y = pick_coord(mpfb_pkg::ROWS, 24);
			end else if (k < 73) begin
				c.func = mpfb_pkg::FN_FILL;
				if ($urandom_range(0, 29) == 0) begin
					c.pos_x = 8'($urandom_range(0, 3));
					c.pos_y = 8'($urandom_range(0, 3));
					c.end_x = 8'hFF;
					c.end_y = 8'hFF;
				end else begin
					c.pos_x = pick_coord(mpfb_pkg::COLUMNS, 32);
					c.pos_y = pick_coord(mpfb_pkg::ROWS, 24);
					c.end_x = pick_end(c.pos_x);
					c.end_y = pick_end(c.pos_y);
				end
			end else if (k < 88) begin
				c.func = mpfb_pkg::FN_READ_BYTE;
				if ($urandom_range(0, 1) == 0)
					c.column_sel = 7'($urandom_range(0, 31));
			end else if (k < 90) begin
				c.func = mpfb_pkg::FN_CLEAR;
			end else if (k < 93) begin
				c.func = 3'($urandom_range(FN_SPARE_MIN, FN_SPARE_MAX));
			end
			cmd_q.push_back(c);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() > 0 || req_valid || readout_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("mono_page_framebuffer: match");
		else
			$display("mono_page_framebuffer: mismatch");
		$finish;
	end

endmodule
